### src/smed_pkg.sv
// ----------------------------------------------------------------------------
// smed_pkg
// Shared constants and a helper for the sliding window median filter.
// ----------------------------------------------------------------------------
package smed_pkg;

   // default window length and sample width
   localparam int WINDOW_DEF       = 15;
   localparam int SAMPLE_WIDTH_DEF = 16;

   // bits needed for an age tag that counts 0 .. window-1
   function automatic int age_bits(input int window);
      int bits;
      bits = 1;
      while ((1 << bits) < window) bits = bits + 1;
      return bits;
   endfunction

endpackage

### src/sliding_window_median_top.sv
// ----------------------------------------------------------------------------
// sliding_window_median_top
// Running median over the last WINDOW signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready carry one signed sample per transaction.
//   rsp_valid/rsp_ready carry the median of the window that includes it.
//   The window is a row of WINDOW cells kept in ascending order; each cell
//   has an age tag, and on every transaction the oldest entry leaves and the
//   new sample is placed by all cells together.
//   The median shows on rsp_* in the cycle after the sample is taken.
//   Throughput: one sample per cycle while the result side keeps up; the
//   single output register sets that figure, since a sample is taken only
//   when that register is empty or being emptied in the same cycle.
//   The element at sorted position WINDOW/2 is reported (upper median for
//   an even window).
//   Reset fills the window with zeros, which take part in the first medians.
//   While rsp_valid is high and rsp_ready low, req_ready is low and the
//   result is held unchanged.
// ----------------------------------------------------------------------------
module sliding_window_median_top #(
   parameter int WINDOW       = smed_pkg::WINDOW_DEF,
   parameter int SAMPLE_WIDTH = smed_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_median
);

   localparam int AGE_WIDTH = smed_pkg::age_bits(WINDOW);
   localparam int MID       = WINDOW / 2;

   logic signed [SAMPLE_WIDTH-1:0] cell_val  [WINDOW];
   logic        [AGE_WIDTH-1:0]    cell_age  [WINDOW];
   logic                           cell_gt   [WINDOW];
   logic                           cell_pre  [WINDOW];
   logic signed [SAMPLE_WIDTH-1:0] cell_next [WINDOW];

   logic                           step;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_median_ff, rsp_median_in;

   // accept when the output register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   // sorted cell row
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      logic signed [SAMPLE_WIDTH-1:0] lo_val, hi_val;
      logic        [AGE_WIDTH-1:0]    lo_age, hi_age;
      logic                           lo_gt, lo_pre, hi_gt;

      if (i == 0) begin : g_lo_edge
         assign lo_val = '0;
         assign lo_age = '0;
         assign lo_gt  = 1'b0;
         assign lo_pre = 1'b0;
      end else begin : g_lo
         assign lo_val = cell_val[i-1];
         assign lo_age = cell_age[i-1];
         assign lo_gt  = cell_gt[i-1];
         assign lo_pre = cell_pre[i-1];
      end

      // past the top the list counts as larger than any sample
      if (i == WINDOW - 1) begin : g_hi_edge
         assign hi_val = '0;
         assign hi_age = '0;
         assign hi_gt  = 1'b1;
      end else begin : g_hi
         assign hi_val = cell_val[i+1];
         assign hi_age = cell_age[i+1];
         assign hi_gt  = cell_gt[i+1];
      end

      smed_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .AGE_WIDTH    (AGE_WIDTH),
         .OLDEST       (WINDOW - 1),
         .RESET_AGE    (WINDOW - 1 - i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (step),
         .sample   (req_sample),
         .lo_val   (lo_val),
         .lo_age   (lo_age),
         .lo_gt    (lo_gt),
         .lo_pre   (lo_pre),
         .hi_val   (hi_val),
         .hi_age   (hi_age),
         .hi_gt    (hi_gt),
         .val      (cell_val[i]),
         .age      (cell_age[i]),
         .gt       (cell_gt[i]),
         .pre      (cell_pre[i]),
         .val_next (cell_next[i])
      );
   end

   // output register next values
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_median_in = rsp_median_ff;
      if (step) begin
         rsp_valid_in  = 1'b1;
         rsp_median_in = cell_next[MID];
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_median_ff <= rsp_median_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

endmodule

### src/smed_cell.sv
// ----------------------------------------------------------------------------
// smed_cell
// One slot of the sorted window: holds a sample and its age, and on each
// transaction drops the oldest entry and inserts the new sample in order.
// ----------------------------------------------------------------------------
module smed_cell #(
   parameter int SAMPLE_WIDTH = smed_pkg::SAMPLE_WIDTH_DEF,
   parameter int AGE_WIDTH    = smed_pkg::age_bits(smed_pkg::WINDOW_DEF),
   parameter int OLDEST       = smed_pkg::WINDOW_DEF - 1,
   parameter int RESET_AGE    = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   // neighbor below (smaller values)
   input  logic signed [SAMPLE_WIDTH-1:0] lo_val,
   input  logic        [AGE_WIDTH-1:0]    lo_age,
   input  logic                           lo_gt,
   input  logic                           lo_pre,
   // neighbor above (larger values)
   input  logic signed [SAMPLE_WIDTH-1:0] hi_val,
   input  logic        [AGE_WIDTH-1:0]    hi_age,
   input  logic                           hi_gt,
   // own state to neighbors
   output logic signed [SAMPLE_WIDTH-1:0] val,
   output logic        [AGE_WIDTH-1:0]    age,
   output logic                           gt,
   output logic                           pre,
   output logic signed [SAMPLE_WIDTH-1:0] val_next
);

   logic signed [SAMPLE_WIDTH-1:0] val_ff, val_in;
   logic        [AGE_WIDTH-1:0]    age_ff, age_in;
   logic                           c_prev, c_cur;
   logic signed [SAMPLE_WIDTH-1:0] prev_val, cur_val;
   logic        [AGE_WIDTH-1:0]    prev_age, cur_age;

   // compare and oldest-entry detection, prefix of removal position
   assign gt  = (val_ff > sample);
   assign pre = lo_pre | (age_ff == AGE_WIDTH'(OLDEST));

   // view of the list with the oldest entry taken out
   always_comb begin
      c_prev   = lo_pre ? gt : lo_gt;
      prev_val = lo_pre ? val_ff : lo_val;
      prev_age = lo_pre ? age_ff : lo_age;
      c_cur    = pre ? hi_gt : gt;
      cur_val  = pre ? hi_val : val_ff;
      cur_age  = pre ? hi_age : age_ff;
   end

   // insertion of the new sample
   always_comb begin
      if (c_prev) begin
         val_in = prev_val;
         age_in = prev_age + AGE_WIDTH'(1);
      end else if (c_cur) begin
         val_in = sample;
         age_in = '0;
      end else begin
         val_in = cur_val;
         age_in = cur_age + AGE_WIDTH'(1);
      end
   end

   // slot registers, zero samples with distinct ages after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
         age_ff <= AGE_WIDTH'(RESET_AGE);
      end else if (step) begin
         val_ff <= val_in;
         age_ff <= age_in;
      end
   end

   assign val      = val_ff;
   assign age      = age_ff;
   assign val_next = val_in;

endmodule

### src/smed_check.sv
// ----------------------------------------------------------------------------
// smed_check
// Port-level checks on the median filter's handshakes.
// ----------------------------------------------------------------------------
module smed_check #(
   parameter int SAMPLE_WIDTH = smed_pkg::SAMPLE_WIDTH_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_median
);

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // every accepted sample yields a result next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted sample produced no result");

   // no new sample while a result is stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("sample accepted over a stalled result");

   // a taken result with no new sample leaves nothing behind
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !(req_valid && req_ready)) |=> !rsp_valid)
      else $error("result repeated");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_median)))
      else $error("stalled result changed");

endmodule

bind sliding_window_median_top smed_check #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_smed_check (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_median (rsp_median)
);

### sim/sliding_window_median_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_median_top_test
// Self-checking bench for the running median filter. Samples are driven over
// the request channel while a local window model predicts every median; each
// response transaction is compared in order against that prediction. Covers
// startup with the zero-filled window, sample extremes, runs of equal samples,
// random traffic under several idle mixes, and a long response stall.
// ----------------------------------------------------------------------------
module sliding_window_median_top_test;

   localparam int WIN         = smed_pkg::WINDOW_DEF;
   localparam int SW          = smed_pkg::SAMPLE_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 140;

   typedef logic signed [SW-1:0] sample_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_valid  = 1'b0;
   logic       req_ready;
   sample_type req_sample = '0;
   logic       rsp_valid;
   logic       rsp_ready  = 1'b0;
   sample_type rsp_median;

   // window model and queue of predicted medians
   sample_type window_hist [WIN] = '{default: '0};
   int         hist_pos = 0;
   sample_type expected_medians [$];

   // traffic shaping
   int         req_idle_pct = 0;
   int         rsp_idle_pct = 0;
   int         rsp_hold_len = 0;
   int         hold_left    = 0;
   sample_type walk_value   = '0;

   // bookkeeping
   int         cycles       = 0;
   int         errors       = 0;
   int         samples_sent = 0;
   int         medians_seen = 0;
   int         input_stalls = 0;

   sliding_window_median_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_median (rsp_median)
   );

   always #5 clock = ~clock;

   // median of the modeled window: sorted position WIN/2, ascending
   function automatic sample_type window_median();
      sample_type sorted [WIN];
      sample_type v;
      int         j;
      for (int i = 0; i < WIN; i++) sorted[i] = window_hist[i];
      for (int i = 1; i < WIN; i++) begin
         v = sorted[i];
         j = i;
         while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = v;
      end
      return sorted[WIN/2];
   endfunction

   // newest sample replaces the oldest, then the median is queued
   task automatic record_sample(input sample_type s);
      window_hist[hist_pos] = s;
      hist_pos = (hist_pos == WIN - 1) ? 0 : hist_pos + 1;
      expected_medians = {expected_medians, window_median()};
      samples_sent++;
   endtask

   // mix of full range, clustered, extreme and slowly drifting samples
   function automatic sample_type random_sample();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         return sample_type'($urandom_range(0, (1 << SW) - 1));
      end else if (pick < 60) begin
         return sample_type'($signed($urandom_range(0, 8)) - 4);
      end else if (pick < 70) begin
         case ($urandom_range(0, 3))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '1;
            default: return '0;
         endcase
      end else begin
         walk_value = walk_value + sample_type'($signed($urandom_range(0, 64)) - 32);
         return walk_value;
      end
   endfunction

   // offer one sample, idling at random first, and wait for the transaction
   task automatic send_sample(input sample_type s);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      record_sample(s);
   endtask

   task automatic pause_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // stop offering and wait until every predicted median has come back
   task automatic drain_medians();
      pause_sender();
      while (expected_medians.size() != 0) @(posedge clock);
   endtask

   // response side: random ready, or a held-off stretch when requested
   always @(negedge clock) begin
      if (rsp_hold_len > 0) begin
         hold_left    = rsp_hold_len;
         rsp_hold_len = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
      if (!reset) begin
         if (req_valid && !req_ready) input_stalls++;
         if (rsp_valid && rsp_ready) begin
            medians_seen++;
            if (expected_medians.size() == 0) begin
               $error("median: unexpected transaction, actual %0d", rsp_median);
               errors++;
            end else begin
               if (rsp_median !== expected_medians[0]) begin
                  $error("median: expected %0d, actual %0d",
                         expected_medians[0], rsp_median);
                  errors++;
               end
               void'(expected_medians.pop_front());
            end
         end
      end
   end

   // zeros from reset still in the window while extremes arrive
   task automatic test_startup_extremes();
      sample_type seq [$];
      seq = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, '1, 1, 0,
              16'sh5555, 16'shAAAA, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN};
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      foreach (seq[i]) send_sample(seq[i]);
   endtask

   // runs of equal samples, ties around the middle position
   task automatic test_equal_samples();
      repeat (8) send_sample(7);
      repeat (3) send_sample(SAMPLE_MIN);
      send_sample(7);
      drain_medians();
   endtask

   task automatic test_random_phase(input int send_pct, input int recv_pct);
      req_idle_pct = send_pct;
      rsp_idle_pct = recv_pct;
      repeat (PHASE_ITEMS) send_sample(random_sample());
      drain_medians();
   endtask

   // long response stall while samples keep coming, so the input backs up
   task automatic test_response_stall();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      rsp_hold_len = 80;
      repeat (30) send_sample(random_sample());
      drain_medians();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_startup_extremes();
      test_equal_samples();
      test_random_phase(19, 57);
      test_random_phase(57, 19);
      test_response_stall();
      test_random_phase(0, 0);

      pause_sender();
      repeat (5) @(posedge clock);
      if (expected_medians.size() != 0) begin
         $error("median: %0d predicted medians never arrived", expected_medians.size());
         errors++;
      end

      $display("covered %0d samples and %0d medians, startup, extremes, ties,",
               samples_sent, medians_seen);
      $display("idle mixes and a long response stall (%0d input stall cycles)",
               input_stalls);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
src/smed_pkg.sv
src/smed_cell.sv
src/sliding_window_median_top.sv
src/smed_check.sv
sim/sliding_window_median_top_test.sv
